[design/nfrt_pkg.sv]
package nfrt_pkg;

  localparam int PosBits = 28;
  // Coordinates are stored and compared at the width of the cell fields.
  localparam int CoordBits = 16;

  typedef enum logic [1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_RELEASE = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    MARK_FREE    = 2'd0,
    MARK_PENDING = 2'd1,
    MARK_WORK    = 2'd2,
    MARK_SPARE   = 2'd3
  } mark_e;

  typedef enum logic [2:0] {
    ST_ACCEPTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_POPPED    = 3'd3,
    ST_EMPTY     = 3'd4,
    ST_RELEASED  = 3'd5,
    ST_NOTFOUND  = 3'd6
  } status_e;

endpackage

[design/nfrt_ram.sv]
module nfrt_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[design/nearest_first_request_table.sv]
// Nearest-first request table.
// Input beats on s_axis carry one operation each: push a cell, pop the
// nearest pending cell, or release a cell in work. Every input beat yields
// exactly one output beat on m_axis with the status, the popped cell and
// the pending and dropped counts. render_distance is written through
// cfg_we_i/cfg_wdata_i; the user must write it only while no
// operation is in flight, as the block itself does not enforce this.
// The slots live in one synchronous RAM with a single read port; each
// operation sweeps every slot in address order, one read per cycle, and
// writes back at most one slot per cycle. A push or release sweeps once
// and then writes back and loads its result into the output register.
// A pop sweeps twice, once for the range drop and once for the nearest
// search through a two-stage squaring pipeline, then writes back and
// loads its result. The next input beat is taken in the cycle after
// the result is loaded into the output register. After reset the block
// first runs a clearing pass that marks every slot free; no input beat
// is taken during it. A result that the receiver does not take stays
// on m_axis while the next operation runs; that operation then waits
// for the output register to free up, and the input stalls until it has.
module nearest_first_request_table #(
  parameter int ENTRIES    = 256,
  parameter int CELL_SIZE  = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [7:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // opcode[1:0], cell_x, cell_y, cell_z, player_pos_x/y/z, player_cell_x/y/z,
  // player_cell_valid, zero fill to 184 bits
  input  logic [183:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], out_x, out_y, out_z, dropped_count[8:0], pending_count[8:0],
  // zero fill to 72 bits
  output logic [71:0]  m_axis_tdata
);

  localparam int AW = $clog2(ENTRIES);
  localparam int CB = nfrt_pkg::CoordBits;
  localparam int EW = 2 + 3 * CB;
  localparam int PB = nfrt_pkg::PosBits;
  localparam int DW = 34;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN, S_DROP, S_NEAR, S_FIN, S_OUT
  } state_e;

  state_e          state_q;
  logic [AW:0]     cnt_q;
  logic [AW-1:0]   raddr;
  logic            rvld_q;
  logic [AW-1:0]   rslot_q;
  logic            we;
  logic [AW-1:0]   waddr;
  logic [EW-1:0]   wdata, rdata;
  logic [7:0]      rd_q;
  logic [183:0]    in_q;
  nfrt_pkg::op_e   op;
  logic            hit_q, free_q;
  logic [AW-1:0]   hit_slot_q, free_slot_q;
  logic [8:0]      pend_q, drop_q;
  logic            best_v_q;
  logic [AW-1:0]   best_q;
  logic [65:0]     best_d_q;
  logic [3*CB-1:0] best_c_q;
  logic [2:0]      st_q;
  logic [3*CB-1:0] res_q;
  logic            ovld_q;
  logic [71:0]     obeat_q;
  // squaring pipeline stage registers
  logic            p1_v_q, p2_v_q;
  logic [AW-1:0]   p1_s_q, p2_s_q;
  logic [3*CB-1:0] p1_c_q, p2_c_q;
  logic [DW-1:0]   p1_m_q [3];
  logic [63:0]     p2_q [3];

  nfrt_pkg::mark_e      rmark;
  logic signed [CB-1:0] rc [3];
  logic signed [CB-1:0] ic [3];
  logic signed [CB-1:0] pc [3];
  logic signed [PB-1:0] pp [3];

  assign op = nfrt_pkg::op_e'(in_q[1:0]);
  assign rmark = nfrt_pkg::mark_e'(rdata[1:0]);

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rc[k] = rdata[2 + k*CB +: CB];
      ic[k] = in_q[2 + k*16 +: CB];
      pp[k] = in_q[50 + k*28 +: PB];
      pc[k] = in_q[134 + k*16 +: CB];
    end
  end

  nfrt_ram #(.Width(EW), .Depth(ENTRIES)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign raddr = cnt_q[AW-1:0];
  // The output register parts the sides: a new beat is taken while a
  // result still waits on m_axis.
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata = obeat_q;

  // range test of a read slot against the player cell
  logic out_rng;
  always_comb begin
    logic signed [CB:0] d;
    out_rng = 1'b0;
    for (int k = 0; k < 3; k++) begin
      d = CB'(0) + ({pc[k][CB-1], pc[k]} - {rc[k][CB-1], rc[k]});
      if (d[CB]) d = -d;
      if (d > $signed({{(CB-8){1'b0}}, 1'b0, rd_q})) out_rng = 1'b1;
    end
  end

  // absolute axis difference to the cell center, then squares
  logic [DW-1:0] mag [3];
  always_comb begin
    logic signed [DW:0] ctr, dd;
    for (int k = 0; k < 3; k++) begin
      ctr = (DW+1)'($signed(rc[k])) * (DW+1)'(CELL_SIZE * 256)
          + (DW+1)'(CELL_SIZE * 128);
      dd = (DW+1)'($signed(pp[k])) - ctr;
      if (dd[DW]) dd = -dd;
      mag[k] = dd[DW-1:0];
    end
  end

  logic [65:0] sum2;
  assign sum2 = 66'(p2_q[0]) + 66'(p2_q[1]) + 66'(p2_q[2]);

  // write port
  always_comb begin
    we = 1'b0;
    waddr = rslot_q;
    wdata = rdata;
    if (state_q == S_CLEAR) begin
      we = 1'b1;
      waddr = cnt_q[AW-1:0];
      wdata = '0;
    end else if (state_q == S_DROP && rvld_q && rmark == nfrt_pkg::MARK_PENDING
                 && in_q[182] && out_rng) begin
      we = 1'b1;
      wdata = {rdata[EW-1:2], nfrt_pkg::MARK_FREE};
    end else if (state_q == S_FIN) begin
      case (op)
        nfrt_pkg::OP_PUSH: begin
          we = !hit_q && free_q;
          waddr = free_slot_q;
          wdata = {in_q[2+2*16 +: CB], in_q[2+16 +: CB], in_q[2 +: CB],
                   nfrt_pkg::MARK_PENDING};
        end
        nfrt_pkg::OP_POP: begin
          we = best_v_q;
          waddr = best_q;
          wdata = {best_c_q, nfrt_pkg::MARK_WORK};
        end
        nfrt_pkg::OP_RELEASE: begin
          we = hit_q;
          waddr = hit_slot_q;
          wdata = {in_q[2+2*16 +: CB], in_q[2+16 +: CB], in_q[2 +: CB],
                   nfrt_pkg::MARK_FREE};
        end
        default: we = 1'b0;
      endcase
    end
  end

  logic same;
  assign same = (rc[0] == ic[0]) && (rc[1] == ic[1]) && (rc[2] == ic[2]);
  logic last_rd;
  assign last_rd = (cnt_q == (AW+1)'(ENTRIES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      cnt_q <= '0;
      rvld_q <= 1'b0;
      ovld_q <= 1'b0;
      obeat_q <= '0;
      rd_q <= 8'd8;
      pend_q <= '0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else begin
      if (cfg_we_i) rd_q <= cfg_wdata_i;
      if (ovld_q && m_axis_tready) ovld_q <= 1'b0;
      rvld_q <= 1'b0;
      rslot_q <= raddr;
      p1_v_q <= 1'b0;
      p2_v_q <= p1_v_q;
      p2_s_q <= p1_s_q;
      p2_c_q <= p1_c_q;
      for (int k = 0; k < 3; k++) p2_q[k] <= p1_m_q[k][DW-1:31] != '0 ?
          64'h4000_0000_0000_0000 : 64'(p1_m_q[k][30:0]) * 64'(p1_m_q[k][30:0]);
      case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == (AW+1)'(ENTRIES - 1)) begin
            state_q <= S_IDLE;
            cnt_q <= '0;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid && s_axis_tready) begin
            in_q <= s_axis_tdata;
            hit_q <= 1'b0;
            free_q <= 1'b0;
            drop_q <= '0;
            best_v_q <= 1'b0;
            cnt_q <= '0;
            state_q <= (nfrt_pkg::op_e'(s_axis_tdata[1:0]) == nfrt_pkg::OP_POP)
                       ? S_DROP : S_SCAN;
            rvld_q <= 1'b0;
          end
        end
        S_SCAN, S_DROP: begin
          if (!last_rd) begin
            cnt_q <= cnt_q + 1'b1;
            rvld_q <= 1'b1;
          end
          if (rvld_q) begin
            if (state_q == S_SCAN) begin
              if (!hit_q && same && (op == nfrt_pkg::OP_PUSH ?
                  rmark == nfrt_pkg::MARK_PENDING || rmark == nfrt_pkg::MARK_WORK :
                  rmark == nfrt_pkg::MARK_WORK)) begin
                hit_q <= 1'b1;
                hit_slot_q <= rslot_q;
              end
              if (!free_q && rmark == nfrt_pkg::MARK_FREE) begin
                free_q <= 1'b1;
                free_slot_q <= rslot_q;
              end
            end else if (we) begin
              drop_q <= drop_q + 1'b1;
              pend_q <= pend_q - 1'b1;
            end
          end
          if (last_rd && !rvld_q) begin
            cnt_q <= '0;
            state_q <= (state_q == S_DROP) ? S_NEAR : S_FIN;
          end
        end
        S_NEAR: begin
          if (!last_rd) begin
            cnt_q <= cnt_q + 1'b1;
            rvld_q <= 1'b1;
          end
          p1_v_q <= rvld_q && rmark == nfrt_pkg::MARK_PENDING;
          p1_s_q <= rslot_q;
          p1_c_q <= rdata[EW-1:2];
          for (int k = 0; k < 3; k++) p1_m_q[k] <= mag[k];
          if (p2_v_q && (!best_v_q || sum2 < best_d_q)) begin
            best_v_q <= 1'b1;
            best_q <= p2_s_q;
            best_d_q <= sum2;
            best_c_q <= p2_c_q;
          end
          if (last_rd && !rvld_q && !p1_v_q && !p2_v_q) state_q <= S_FIN;
        end
        S_FIN: begin
          res_q <= '0;
          st_q <= nfrt_pkg::ST_NOTFOUND;
          if (op != nfrt_pkg::OP_POP) drop_q <= '0;
          case (op)
            nfrt_pkg::OP_PUSH: begin
              if (hit_q) st_q <= nfrt_pkg::ST_DUPLICATE;
              else if (!free_q) st_q <= nfrt_pkg::ST_FULL;
              else begin
                st_q <= nfrt_pkg::ST_ACCEPTED;
                pend_q <= pend_q + 1'b1;
              end
            end
            nfrt_pkg::OP_POP: begin
              if (best_v_q) begin
                st_q <= nfrt_pkg::ST_POPPED;
                res_q <= best_c_q;
                pend_q <= pend_q - 1'b1;
              end else st_q <= nfrt_pkg::ST_EMPTY;
            end
            nfrt_pkg::OP_RELEASE: if (hit_q) st_q <= nfrt_pkg::ST_RELEASED;
            default: st_q <= nfrt_pkg::ST_NOTFOUND;
          endcase
          state_q <= S_OUT;
        end
        S_OUT: begin
          // The result moves into the output register once the previous
          // beat has gone or goes out at this edge.
          if (!ovld_q || m_axis_tready) begin
            ovld_q <= 1'b1;
            obeat_q <= {3'd0, pend_q, drop_q, res_q, st_q};
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_no_in_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == S_IDLE) else $error("ready while busy");
  a_out_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ovld_q) |-> $past(state_q) == S_OUT) else $error("stray result");
  a_no_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> !we) else $error("write while idle");

endmodule
